FILE: sv/afd_pkg.sv
package afd_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;

  localparam int CAP_W = 17;
  localparam int CNT_W = 17;
  localparam int LEN_W = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'd256;

  // APB register indexes (word index = paddr[2])
  localparam logic REG_CAP = 1'b0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROG  = 2'd0,
    ST_OK    = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  // One classified body byte, front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             trunc;
  } body_ent_t;

endpackage

FILE: sv/api_frame_deframer.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | in_rx_byte[7:0]
// out      | out_valid / out_stall  | out_data_byte, out_byte_index, out_frame_length,
//          |                        | out_last, out_status
// config   | APB psel/penable/...   | body_capacity at byte address 0
//
// One item per cycle sustained while in_stall is low; an accepted body byte is queued, then registered on out.
// The front classifies combinationally; a 4-entry queue feeds the back's output register.
// in_stall rises only when the queue holds 4 items (out stalled long enough).
// Synchronous active-low reset: hunting for 0x7E, body_capacity = 256, queue empty.
module api_frame_deframer import afd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic [LEN_W-1:0] out_byte_index,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_last,
  output logic [1:0]       out_status,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;
  logic             in_acc;
  logic             q_push, q_pop, q_full, q_empty;
  body_ent_t        q_wdata, q_rdata;

  // --- configuration register ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAP) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAP) ? {{(32-CAP_W){1'b0}}, cap_r} : 32'd0;

  // --- input handshake ---
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  // front: start/length parsing, body count and frame end decision
  afd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .cap     (cap_r),
    .push    (q_push),
    .ent     (q_wdata)
  );

  // decoupling queue between front and back
  afd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: running checksum, final status, output register
  afd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ent              (q_rdata),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule

FILE: sv/afd_front.sv
module afd_front import afd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       rx_byte,
  input  logic [CAP_W-1:0] cap,
  output logic             push,
  output body_ent_t        ent
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [CNT_W-1:0] body_len_r, body_len_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] count_inc;
  logic             is_start;

  assign cap_eff   = (cap == '0) ? CNT_W'(1) : cap;
  assign count_inc = count_r + CNT_W'(1);
  assign is_start  = (rx_byte == START_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      len_hi_r   <= '0;
      body_len_r <= '0;
      count_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      len_hi_r   <= len_hi_nxt;
      body_len_r <= body_len_nxt;
      count_r    <= count_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    len_hi_nxt   = len_hi_r;
    body_len_nxt = body_len_r;
    count_nxt    = count_r;
    push         = 1'b0;
    ent.data     = rx_byte;
    ent.idx      = count_r[LEN_W-1:0];
    ent.len      = LEN_W'(body_len_r - CNT_W'(1));
    ent.last     = 1'b0;
    ent.trunc    = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (is_start) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (!is_start) begin
            len_hi_nxt = rx_byte;
            phase_nxt  = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (is_start) begin
            phase_nxt = PH_LEN_HI;
          end else begin
            body_len_nxt = {1'b0, len_hi_r, rx_byte} + CNT_W'(1);
            count_nxt    = '0;
            phase_nxt    = PH_BODY;
          end
        end
        PH_BODY: begin
          push      = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= body_len_r) begin
            ent.last  = 1'b1;
            phase_nxt = PH_HUNT;
          end else if (count_inc >= cap_eff) begin
            ent.last  = 1'b1;
            ent.trunc = 1'b1;
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  a_body_push: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_BODY) |-> push)
    else $error("body byte not queued");

  a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ent.last) |=> (phase_r == PH_HUNT))
    else $error("frame end did not return to hunt");

endmodule

FILE: sv/afd_fifo.sv
module afd_fifo import afd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  body_ent_t wdata,
  output logic      full,
  input  logic      pop,
  output body_ent_t rdata,
  output logic      empty
);

  body_ent_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule

FILE: sv/afd_back.sv
module afd_back import afd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  body_ent_t        ent,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic [LEN_W-1:0] out_byte_index,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_last,
  output logic [1:0]       out_status
);

  logic             valid_r;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       data_r;
  logic [LEN_W-1:0] idx_r, len_r;
  logic             last_r;
  status_t          status_r, status_nxt;

  assign pop = !empty && (!valid_r || !out_stall);

  // sum restarts on the first body byte of each frame
  assign sum_nxt = ((ent.idx == '0) ? 8'h00 : sum_r) + ent.data;

  always_comb begin
    if (!ent.last)      status_nxt = ST_PROG;
    else if (ent.trunc) status_nxt = ST_TRUNC;
    else if (sum_nxt == 8'hFF) status_nxt = ST_OK;
    else                status_nxt = ST_BAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        sum_r   <= sum_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r   <= ent.data;
      idx_r    <= ent.idx;
      len_r    <= ent.len;
      last_r   <= ent.last;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_byte    = data_r;
  assign out_byte_index   = idx_r;
  assign out_frame_length = len_r;
  assign out_last         = last_r;
  assign out_status       = status_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((status_r != ST_PROG) == last_r))
    else $error("final status without last, or last without status");

  a_no_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !pop)
    else $error("output register overwritten while held");

endmodule

FILE: bench/api_frame_deframer_tb.sv
module api_frame_deframer_tb;
  import afd_pkg::*;

  // Cycles with no item moving on either channel before the run is called hung.
  // Even long runs of random gaps or stalls at 45% stay well below this limit.
  localparam int WATCHDOG_LIMIT = 4000;
  // Body bytes pass through a 4-deep queue and then the output register.
  // Header and hunt bytes produce nothing, so let the pipe settle this long.
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 30;

  // One expected body byte as it should leave the out channel
  typedef struct {
    logic [7:0]       data;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic             last;
    status_t          st;
  } body_byte_t;

  logic             clk;
  logic             rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_data_byte;
  logic [LEN_W-1:0] out_byte_index;
  logic [LEN_W-1:0] out_frame_length;
  logic             out_last;
  logic [1:0]       out_status;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Serial bytes waiting to be offered, and body bytes the deframer still owes us
  logic [7:0] line_bytes[$];
  body_byte_t body_bytes_due[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Shadow of the deframer: capacity register plus parser state
  logic [CAP_W-1:0] cap_q = CAP_RESET;
  phase_t           phase_q = PH_HUNT;
  logic [7:0]       len_hi_q = '0;
  logic [CNT_W-1:0] body_len_q = '0;
  logic [CNT_W-1:0] body_cnt_q = '0;
  logic [7:0]       sum_q = '0;

  body_byte_t want_byte;

  api_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_REPORTS) begin
      $display("mismatch %s: got %0h, want %0h", what, got, want);
    end
    errors++;
  endtask

  // Advance the shadow parser by one accepted byte; body bytes queue an expectation.
  task automatic deframe_byte(input logic [7:0] b);
    body_byte_t e;
    logic [CAP_W-1:0] eff_cap;
    case (phase_q)
      PH_HUNT: begin
        if (b == START_BYTE) phase_q = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        // a second start byte just restarts the length field
        if (b != START_BYTE) begin
          len_hi_q = b;
          phase_q = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (b == START_BYTE) begin
          phase_q = PH_LEN_HI;
        end else begin
          body_len_q = {1'b0, len_hi_q, b} + 17'd1;
          body_cnt_q = '0;
          sum_q = '0;
          phase_q = PH_BODY;
        end
      end
      default: begin
        // body: 0x7e is plain data here
        eff_cap = (cap_q == '0) ? 17'd1 : cap_q;
        e.data = b;
        e.idx = body_cnt_q[LEN_W-1:0];
        e.len = LEN_W'(body_len_q - 17'd1);
        sum_q = sum_q + b;
        body_cnt_q = body_cnt_q + 17'd1;
        e.last = 1'b0;
        e.st = ST_PROG;
        // a frame that fits exactly ends normally, never truncated
        if (body_cnt_q >= body_len_q) begin
          e.last = 1'b1;
          if (sum_q == 8'hFF) e.st = ST_OK;
          else e.st = ST_BAD;
          phase_q = PH_HUNT;
        end else if (body_cnt_q >= eff_cap) begin
          // cut: leftover bytes of the frame just go to the hunter
          e.last = 1'b1;
          e.st = ST_TRUNC;
          phase_q = PH_HUNT;
        end
        body_bytes_due.push_back(e);
      end
    endcase
  endtask

  // Driver: holds valid and payload while stalled, draws a gap otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= line_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted body byte against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (body_bytes_due.size() == 0) begin
          report_mismatch("body byte with nothing pending", 32'(out_data_byte), '0);
        end else begin
          want_byte = body_bytes_due.pop_front();
          if (out_data_byte !== want_byte.data)
            report_mismatch("data_byte", 32'(out_data_byte), 32'(want_byte.data));
          if (out_byte_index !== want_byte.idx)
            report_mismatch("byte_index", 32'(out_byte_index), 32'(want_byte.idx));
          if (out_frame_length !== want_byte.len)
            report_mismatch("frame_length", 32'(out_frame_length), 32'(want_byte.len));
          if (out_last !== want_byte.last)
            report_mismatch("last", 32'(out_last), 32'(want_byte.last));
          if (out_status !== want_byte.st)
            report_mismatch("status", 32'(out_status), 32'(want_byte.st));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles where no item moves on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_rx(input logic [7:0] b);
    line_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Header plus n_send body bytes; with good_sum the checksum byte closes to 0xff.
  task automatic push_frame(input logic [15:0] len, input int unsigned n_send,
                            input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    push_rx(START_BYTE);
    push_rx(len[15:8]);
    push_rx(len[7:0]);
    for (int unsigned i = 0; i < n_send; i++) begin
      b = 8'($urandom_range(255));
      if (good_sum && i == len) b = 8'hFF - sum;
      sum = sum + b;
      push_rx(b);
    end
  endtask

  // Wait until every offered byte is taken and every body byte has come out,
  // then give header/hunt bytes time to clear the pipe.
  task automatic drain();
    while (bytes_taken != bytes_queued || body_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back the capacity register.
  task automatic write_cap_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // pready is tied high, so the write lands at this edge
    if (addr[2] == REG_CAP) cap_q = data[CAP_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(cap_q))
      report_mismatch("body_capacity readback", prdata, 32'(cap_q));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some long or cut frames,
  // and some noise (stray bytes, bare start bytes, broken headers).
  task automatic gen_traffic(input int unsigned n);
    int unsigned eff_cap;
    int unsigned start;
    int unsigned len;
    int unsigned n_send;
    int r;
    eff_cap = (cap_q == '0) ? 1 : cap_q;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      r = $urandom_range(99);
      if (r < 72) begin
        len = $urandom_range(12);
        push_frame(16'(len), len + 1, $urandom_range(9) < 7);
      end else if (r < 86) begin
        if (eff_cap <= 300 && $urandom_range(1) == 1) len = $urandom_range(65535);
        else len = $urandom_range(300, 13);
        n_send = len + 1;
        if (n_send > eff_cap + 6) n_send = eff_cap + $urandom_range(6);
        push_frame(16'(len), n_send, 1'b1);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(3) == 0) push_rx(START_BYTE);
          else push_rx(8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] cap, input int send_pct, input int stl_pct,
                           input int unsigned n);
    drain();
    write_cap_reg(3'd0, cap);
    send_idle_pct <= send_pct;
    stall_pct <= stl_pct;
    gen_traffic(n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset capacity 256, no gaps. Readback of the reset value first:
    // write to the unused word so nothing changes.
    write_cap_reg(3'd4, 32'h0001_FFFF);
    // junk while hunting, start byte in the high and low length byte, then an
    // empty-length frame whose lone byte is the checksum
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(8'h7D);
    push_rx(START_BYTE);
    push_rx(START_BYTE);
    push_rx(8'h00);
    push_rx(START_BYTE);
    push_rx(8'h00);
    push_rx(8'h00);
    push_rx(8'hFF);
    // start bytes inside the body are data; sum 0xfc gives a bad checksum
    push_rx(START_BYTE);
    push_rx(8'h00);
    push_rx(8'h02);
    push_rx(START_BYTE);
    push_rx(START_BYTE);
    push_rx(8'h00);
    // sender stops mid-frame until everything owed has come out
    push_rx(START_BYTE);
    push_rx(8'h00);
    push_rx(8'h03);
    push_rx(8'hA0);
    push_rx(8'h0F);
    drain();
    push_rx(8'h10);
    push_rx(8'h40);

    // exact fit ends normally; a longer frame is cut and its tail hunted
    drain();
    write_cap_reg(3'd0, 32'd3);
    push_frame(16'd2, 3, 1'b1);
    push_frame(16'd5, 6, 1'b1);
    // zero capacity behaves as one
    drain();
    write_cap_reg(3'd0, 32'd0);
    push_frame(16'd1, 2, 1'b1);
    // upper pwdata bits are dropped: capacity becomes 5
    drain();
    write_cap_reg(3'd0, 32'hFFFE_0005);
    push_frame(16'hFFFF, 8, 1'b1);

    // random phases across capacities and gap/stall mixes
    run_phase(32'd256,    0,  0, 60);
    run_phase(32'd256,   45,  0, 60);
    run_phase(32'd5,      0, 45, 50);
    run_phase(32'd1,     13, 13, 50);
    run_phase(32'h1FFFF,  0, 45, 50);
    run_phase(32'd65536, 13, 13, 50);
    run_phase(32'd17,     0,  0, 45);
    run_phase(32'd300,   45,  0, 40);
    run_phase(32'd2,      0, 45, 40);

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/afd_pkg.sv
sv/afd_front.sv
sv/afd_fifo.sv
sv/afd_back.sv
sv/api_frame_deframer.sv
bench/api_frame_deframer_tb.sv
